[hdl/selsort_pkg.sv]
`timescale 1ns / 1ps

package selsort_pkg;

	localparam int DATA_WIDTH = 32;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic issue;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last_issue;
		logic rd_busy;
		logic last_pass;
		logic out_free;
	} sts_t;

endpackage

[hdl/selection_sorter.sv]
`timescale 1ns / 1ps

// Collects signed values, one item per cycle, until an item with tlast arrives,
// then returns them in ascending order with tlast on the last one. At most
// CAPACITY values are kept: items beyond that are discarded and every result
// of that run carries tuser set. No item is taken while a run is being sorted
// or returned. Each result position scans the remaining entries through the
// single read port of the element store; the smallest one is returned and the
// entry at the head of the scan is written into its slot.
module selection_sorter
	import selsort_pkg::*;
#(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DATA_WIDTH-1:0] s_tdata,  // value
	input  logic                  s_tlast,  // last_item
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DATA_WIDTH-1:0] m_tdata,  // sorted_value
	output logic                  m_tlast,  // final_result
	output logic                  m_tuser   // dropped
);

	cmd_t cmd;
	sts_t sts;

	selsort_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	selsort_dp #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_value  (signed'(s_tdata)),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast),
		.out_drop  (m_tuser)
	);

endmodule

[hdl/selsort_ctrl.sv]
`timescale 1ns / 1ps

module selsort_ctrl
	import selsort_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_valid && in_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.last_issue) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!sts.rd_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = sts.last_pass ? ST_LOAD : ST_SCAN;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_LOAD: begin
				in_ready  = 1'b1;
				cmd.load  = in_valid;
				cmd.start = in_valid && in_last;
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
			end
			ST_WAIT: begin
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

[hdl/selsort_dp.sv]
`timescale 1ns / 1ps

module selsort_dp
	import selsort_pkg::*;
#(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output sts_t                         sts,
	input  logic signed [DATA_WIDTH-1:0] in_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic        [DATA_WIDTH-1:0] out_data,
	output logic                         out_last,
	output logic                         out_drop
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];

	logic [CW-1:0] cnt_q;
	logic          overflow_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] last_idx;

	logic signed [VALUE_WIDTH-1:0] rdata_s1;
	logic                          vld_s1;
	logic [AW-1:0]                 idx_s1;

	logic [AW-1:0]                 best_q;
	logic signed [VALUE_WIDTH-1:0] best_val_q;
	logic signed [VALUE_WIDTH-1:0] head_val_q;
	logic [AW-1:0]                 best_d;
	logic signed [VALUE_WIDTH-1:0] best_val_d;
	logic signed [VALUE_WIDTH-1:0] head_val_d;

	logic signed [VALUE_WIDTH-1:0] in_ext;
	logic                          has_room;
	logic                          out_valid_q;

	assign in_ext   = VALUE_WIDTH'(in_value);
	assign has_room = (cnt_q < CW'(CAPACITY));
	assign last_idx = AW'(cnt_q - CW'(1));

	assign sts.last_issue = (j_q == last_idx);
	assign sts.rd_busy    = vld_s1;
	assign sts.last_pass  = (i_q == last_idx);
	assign sts.out_free   = !out_valid_q || out_ready;

	// element store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			mem[AW'(cnt_q)] <= in_ext;
		end else if (cmd.emit) begin
			mem[best_q] <= head_val_q;
		end
		if (cmd.issue) begin
			rdata_s1 <= mem[j_q];
		end
		idx_s1 <= j_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			overflow_q <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			vld_s1     <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.load) begin
				if (has_room) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				i_q <= '0;
				j_q <= '0;
			end else if (cmd.issue) begin
				j_q <= j_q + AW'(1);
			end else if (cmd.emit) begin
				i_q <= i_q + AW'(1);
				j_q <= i_q + AW'(1);
			end
			if (cmd.emit && sts.last_pass) begin
				cnt_q      <= '0;
				overflow_q <= 1'b0;
			end
		end
	end

	// running minimum, first smallest wins on ties
	always_comb begin
		best_d     = best_q;
		best_val_d = best_val_q;
		head_val_d = head_val_q;
		if (vld_s1) begin
			if (idx_s1 == i_q) begin
				best_d     = idx_s1;
				best_val_d = rdata_s1;
				head_val_d = rdata_s1;
			end else if (rdata_s1 < best_val_q) begin
				best_d     = idx_s1;
				best_val_d = rdata_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		best_q     <= best_d;
		best_val_q <= best_val_d;
		head_val_q <= head_val_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data <= DATA_WIDTH'(best_val_q);
			out_last <= sts.last_pass;
			out_drop <= overflow_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hdl/selsort_checker.sv]
`timescale 1ns / 1ps

module selsort_checker
	import selsort_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [DATA_WIDTH-1:0] s_tdata,
	input logic                  s_tlast,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [DATA_WIDTH-1:0] m_tdata,
	input logic                  m_tlast,
	input logic                  m_tuser
);

	// a run closes the input until its results are out
	a_close_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input still open after last item");

	// no input while results of a run remain
	a_no_load_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |-> !s_tready)
		else $error("input open while run not finished");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind selection_sorter selsort_checker u_chk (.*);

[test/selection_sorter_checker.sv]
`timescale 1ns / 1ps

module selection_sorter_checker
	import selsort_pkg::*;
#(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [DATA_WIDTH-1:0] s_tdata,
	input  logic                  s_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [DATA_WIDTH-1:0] m_tdata,
	input  logic                  m_tlast,
	input  logic                  m_tuser,
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct {
		logic signed [DATA_WIDTH-1:0] value;
		logic                         run_end;
		logic                         dropped;
	} sorted_item_t;

	sorted_item_t                 sorted_q[$];
	logic signed [DATA_WIDTH-1:0] held[CAPACITY];
	int                           held_count;
	logic                         overflow;

	function automatic logic signed [DATA_WIDTH-1:0] narrow_to_width(logic [DATA_WIDTH-1:0] d);
		logic signed [VALUE_WIDTH-1:0] v;
		v = d[VALUE_WIDTH-1:0];
		return DATA_WIDTH'(v);
	endfunction

	task automatic take_value(logic [DATA_WIDTH-1:0] d, logic mark);
		int                           best;
		logic signed [DATA_WIDTH-1:0] swap;
		sorted_item_t                 r;
		if (held_count < CAPACITY) begin
			held[held_count] = narrow_to_width(d);
			held_count++;
		end else begin
			overflow = 1'b1;
		end
		if (mark) begin
			// first smallest wins on ties
			for (int i = 0; i + 1 < held_count; i++) begin
				best = i;
				for (int j = i + 1; j < held_count; j++)
					if (held[j] < held[best])
						best = j;
				swap = held[i];
				held[i] = held[best];
				held[best] = swap;
			end
			for (int k = 0; k < held_count; k++) begin
				r.value = held[k];
				r.run_end = (k == held_count - 1);
				r.dropped = overflow;
				sorted_q.push_back(r);
			end
			held_count = 0;
			overflow = 1'b0;
		end
	endtask

	task automatic check_result();
		sorted_item_t r;
		if (sorted_q.size() == 0) begin
			$error("unexpected item: sorted_value %0d final_result %0b dropped %0b",
				$signed(m_tdata), m_tlast, m_tuser);
			mismatches++;
		end else begin
			r = sorted_q.pop_front();
			if ($signed(m_tdata) !== r.value) begin
				$error("sorted_value: expected %0d, actual %0d", r.value, $signed(m_tdata));
				mismatches++;
			end
			if (m_tlast !== r.run_end) begin
				$error("final_result: expected %0b, actual %0b", r.run_end, m_tlast);
				mismatches++;
			end
			if (m_tuser !== r.dropped) begin
				$error("dropped: expected %0b, actual %0b", r.dropped, m_tuser);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_q.delete();
			held_count = 0;
			overflow = 1'b0;
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready)
				take_value(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				check_result();
			outstanding = sorted_q.size();
		end
	end

endmodule

[test/selection_sorter_tb.sv]
`timescale 1ns / 1ps

module selection_sorter_tb;
	import selsort_pkg::*;

	localparam int CAPACITY      = 64;
	localparam int VALUE_WIDTH   = 32;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 200;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DATA_WIDTH-1:0] s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [DATA_WIDTH-1:0] m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	int   mismatches;
	int   outstanding;
	logic hold_go   = 1'b0;
	logic hold_done = 1'b0;
	logic calm      = 1'b0;

	always #4 clk = ~clk;

	selection_sorter #(
		.CAPACITY   (CAPACITY),
		.VALUE_WIDTH(VALUE_WIDTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	selection_sorter_checker #(
		.CAPACITY   (CAPACITY),
		.VALUE_WIDTH(VALUE_WIDTH)
	) sort_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [DATA_WIDTH-1:0] random_value();
		case ($urandom_range(0, 5))
			0: return DATA_WIDTH'($urandom_range(0, 8)) - DATA_WIDTH'(4);
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic offer(logic [DATA_WIDTH-1:0] v, logic mark);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tlast <= mark;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_list(logic [DATA_WIDTH-1:0] vals[$]);
		foreach (vals[i])
			offer(vals[i], i == vals.size() - 1);
	endtask

	task automatic send_run(int n);
		for (int i = 0; i < n; i++)
			offer(random_value(), i == n - 1);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
	endtask

	// result side
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 8)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [DATA_WIDTH-1:0] run[$];
		int                    lengths[$];
		int                    total;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single values, extremes, ties, both orders
		run = '{32'h7fff_ffff};
		send_list(run);
		run = '{32'h8000_0000};
		send_list(run);
		run = '{32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001};
		send_list(run);
		run = '{32'd7, 32'd7, 32'hffff_fffd, 32'd7, 32'hffff_fffd};
		send_list(run);
		run = '{32'd5, 32'd4, 32'd3, 32'd2, 32'd1};
		send_list(run);
		run = '{32'hffff_fff8, 32'hffff_fffc, 32'd0, 32'd4, 32'd8};
		send_list(run);
		drain();

		// mostly short runs, plus a full store and two overflowing ones
		total = 0;
		while (total < 70) begin
			lengths.push_back($urandom_range(1, 12));
			total += lengths[lengths.size() - 1];
		end
		lengths.insert($urandom_range(0, lengths.size()), CAPACITY);
		lengths.insert($urandom_range(0, lengths.size()), CAPACITY + 1);
		lengths.insert($urandom_range(0, lengths.size()), CAPACITY + 2);

		// receiver holds off while runs keep coming
		hold_go = 1'b1;
		foreach (lengths[r]) begin
			if (r == lengths.size() / 2)
				drain();
			if (r == lengths.size() - 3)
				calm = 1'b1;
			send_run(lengths[r]);
		end
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[selection_sorter.f]
hdl/selsort_pkg.sv
hdl/selsort_ctrl.sv
hdl/selsort_dp.sv
hdl/selection_sorter.sv
hdl/selsort_checker.sv
test/selection_sorter_checker.sv
test/selection_sorter_tb.sv
